// ===== rtl/sltok_pkg.sv =====
// Shared types and constants for the shell line tokenizer.
// Holds the result record, the push bundle into the result queue and all code values.
// No dependencies.
package sltok_pkg;

    localparam int CP_W        = 21;
    localparam int BC_W        = 3;
    localparam int TOK_W       = 9;
    localparam int POS_W       = 13;
    localparam int LINE_BYTES  = 4096;
    localparam int TOKEN_CAP   = 256;

    // results one transaction can cause, and the queue that holds them
    localparam int MAX_RES     = 3;
    localparam int RES_CNT_W   = 2;
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = 3;
    localparam int QCNT_W      = 4;

    localparam logic [CP_W-1:0] CH_SPACE = 21'h000020;
    localparam logic [CP_W-1:0] CH_PIPE  = 21'h00007C;
    localparam logic [CP_W-1:0] CH_QUOTE = 21'h000027;

    localparam logic [1:0] KIND_CHAR      = 2'd0;
    localparam logic [1:0] KIND_CLOSE     = 2'd1;
    localparam logic [1:0] KIND_ERROR     = 2'd2;
    localparam logic [1:0] KIND_LINE_DONE = 2'd3;

    localparam logic [1:0] TYPE_TEXT  = 2'd0;
    localparam logic [1:0] TYPE_SPACE = 2'd1;
    localparam logic [1:0] TYPE_PIPE  = 2'd2;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_UNCLOSED = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [1:0]       kind;
        logic [1:0]       token_type;
        logic [CP_W-1:0]  out_char;
        logic [TOK_W-1:0] token_number;
        logic [POS_W-1:0] byte_ofs;
        logic [POS_W-1:0] byte_len;
        logic [POS_W-1:0] char_ofs;
        logic [POS_W-1:0] char_len;
        logic [1:0]       error_code;
        logic             last;
    } result_t;

    typedef struct packed {
        logic [RES_CNT_W-1:0]       count;
        result_t [MAX_RES-1:0]      res;
    } push_t;

endpackage

// ===== rtl/shell_line_tokenizer_core.sv =====
// Top level of the shell line tokenizer: splits a decoded character stream into
// text, space-run and pipe tokens. Depends on sltok_pkg, sltok_scan and sltok_queue.
//
//   channel   direction  handshake           carries
//   s_*       in         s_valid / s_ready   one character or the end-of-line marker
//   m_*       out        m_valid / m_ready   one result record (char, close, error, done)
//   cfg_*     in         cfg_wr_en           token_limit, written with no wait
//
// A transaction is decoded in the cycle it is taken and its results (zero to three)
// are registered into an eight-entry result queue, whose head record drives m_*.
// One input transaction can be taken every cycle while the queue has room for three
// more records, so the sustained rate is one item per cycle for items that cause at most
// one result while m_ready is high, else set by the one-record-per-cycle result port.
// Reset (aresetn low at a clock edge) clears the line state, empties the queue and
// sets token_limit to 256. A stalled result port holds the head record steady.
module shell_line_tokenizer_core (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_wr_en,
    input  logic [sltok_pkg::TOK_W-1:0]     cfg_wr_data,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [sltok_pkg::CP_W-1:0]      s_code_point,
    input  logic [sltok_pkg::BC_W-1:0]      s_byte_count,
    input  logic                            s_end_marker,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_kind,
    output logic [1:0]                      m_token_type,
    output logic [sltok_pkg::CP_W-1:0]      m_out_char,
    output logic [sltok_pkg::TOK_W-1:0]     m_token_number,
    output logic [sltok_pkg::POS_W-1:0]     m_byte_ofs,
    output logic [sltok_pkg::POS_W-1:0]     m_byte_len,
    output logic [sltok_pkg::POS_W-1:0]     m_char_ofs,
    output logic [sltok_pkg::POS_W-1:0]     m_char_len,
    output logic [1:0]                      m_error_code,
    output logic                            m_last
);

    sltok_pkg::push_t    push;
    sltok_pkg::result_t  head;
    logic                room;
    logic                accept;

    // take a transaction whenever the queue can absorb its worst-case burst
    assign s_ready = room;
    assign accept  = s_valid && s_ready;

    // decode the character against the line state and advance it
    sltok_scan u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .accept_i     (accept),
        .code_point_i (s_code_point),
        .byte_count_i (s_byte_count),
        .end_marker_i (s_end_marker),
        .push_o       (push)
    );

    // hold results until the downstream side takes them, one per transaction
    sltok_queue u_queue (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push_i       (push),
        .pop_ready_i  (m_ready),
        .head_valid_o (m_valid),
        .head_o       (head),
        .room_o       (room)
    );

    // drive the result fields from the queue head
    assign m_kind         = head.kind;
    assign m_token_type   = head.token_type;
    assign m_out_char     = head.out_char;
    assign m_token_number = head.token_number;
    assign m_byte_ofs     = head.byte_ofs;
    assign m_byte_len     = head.byte_len;
    assign m_char_ofs     = head.char_ofs;
    assign m_char_len     = head.char_len;
    assign m_error_code   = head.error_code;
    assign m_last         = head.last;

endmodule

// ===== rtl/sltok_scan.sv =====
// Scanner state and per-character decode for the shell line tokenizer.
// Holds the line state and the token limit register; emits up to three results per transaction.
// Depends on sltok_pkg.
module sltok_scan (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [sltok_pkg::TOK_W-1:0]   cfg_wr_data,
    input  logic                          accept_i,
    input  logic [sltok_pkg::CP_W-1:0]    code_point_i,
    input  logic [sltok_pkg::BC_W-1:0]    byte_count_i,
    input  logic                          end_marker_i,
    output sltok_pkg::push_t              push_o
);

    typedef enum logic [2:0] {
        MODE_NORMAL,
        MODE_SPACE,
        MODE_STRING,
        MODE_QUOTE,
        MODE_ERROR
    } mode_t;

    mode_t                         mode_reg,   mode_next;
    logic                          pend_reg,   pend_next;
    logic [sltok_pkg::POS_W-1:0]   bpos_reg,   bpos_next;
    logic [sltok_pkg::POS_W-1:0]   cpos_reg,   cpos_next;
    logic [sltok_pkg::POS_W-1:0]   borg_reg,   borg_next;
    logic [sltok_pkg::POS_W-1:0]   corg_reg,   corg_next;
    logic [sltok_pkg::TOK_W-1:0]   tokens_reg, tokens_next;
    logic [sltok_pkg::TOK_W-1:0]   limit_reg;
    logic [sltok_pkg::TOK_W-1:0]   limit_eff;
    logic [sltok_pkg::BC_W-1:0]    bc;
    sltok_pkg::push_t              push_w;

    function automatic sltok_pkg::result_t simple_rec(
        input logic [1:0]                kind,
        input logic [1:0]                ttype,
        input logic [sltok_pkg::CP_W-1:0] ch,
        input logic [1:0]                err
    );
        sltok_pkg::result_t r;
        r            = '0;
        r.kind       = kind;
        r.token_type = ttype;
        r.out_char   = ch;
        r.error_code = err;
        return r;
    endfunction

    function automatic sltok_pkg::result_t close_rec(
        input logic [1:0]                  ttype,
        input logic [sltok_pkg::TOK_W-1:0] num,
        input logic [sltok_pkg::POS_W-1:0] borg,
        input logic [sltok_pkg::POS_W-1:0] bpos,
        input logic [sltok_pkg::POS_W-1:0] corg,
        input logic [sltok_pkg::POS_W-1:0] cpos
    );
        sltok_pkg::result_t r;
        r              = '0;
        r.kind         = sltok_pkg::KIND_CLOSE;
        r.token_type   = ttype;
        r.token_number = num;
        r.byte_ofs     = borg;
        r.byte_len     = bpos - borg;
        r.char_ofs     = corg;
        r.char_len     = cpos - corg;
        return r;
    endfunction

    assign bc        = (byte_count_i == '0) ? sltok_pkg::BC_W'(1) : byte_count_i;
    assign limit_eff = (limit_reg < sltok_pkg::TOK_W'(sltok_pkg::TOKEN_CAP)) ?
                       limit_reg : sltok_pkg::TOK_W'(sltok_pkg::TOKEN_CAP);

    always_comb begin
        logic                          fail;
        logic                          pre_close;
        logic [1:0]                    ctype;
        logic [sltok_pkg::TOK_W-1:0]   done_count;
        logic [sltok_pkg::POS_W:0]     bpos_sum;
        sltok_pkg::result_t            rec;

        mode_next   = mode_reg;
        pend_next   = pend_reg;
        bpos_next   = bpos_reg;
        cpos_next   = cpos_reg;
        borg_next   = borg_reg;
        corg_next   = corg_reg;
        tokens_next = tokens_reg;
        push_w      = '0;
        fail        = 1'b0;
        pre_close   = 1'b0;
        done_count  = tokens_reg;
        rec         = '0;
        ctype       = (mode_reg == MODE_SPACE) ? sltok_pkg::TYPE_SPACE : sltok_pkg::TYPE_TEXT;
        bpos_sum    = {1'b0, bpos_reg} + (sltok_pkg::POS_W + 1)'(bc);

        if (end_marker_i) begin
            // line ends: every outcome clears the line state
            mode_next   = MODE_NORMAL;
            pend_next   = 1'b0;
            bpos_next   = '0;
            cpos_next   = '0;
            borg_next   = '0;
            corg_next   = '0;
            tokens_next = '0;
            if (mode_reg == MODE_STRING) begin
                push_w.res[push_w.count] = simple_rec(sltok_pkg::KIND_ERROR,
                    sltok_pkg::TYPE_TEXT, '0, sltok_pkg::ERR_UNCLOSED);
                push_w.count = push_w.count + 2'd1;
            end else if (mode_reg != MODE_ERROR) begin
                if (mode_reg == MODE_SPACE || mode_reg == MODE_QUOTE || pend_reg) begin
                    if (tokens_reg >= limit_eff) begin
                        fail = 1'b1;
                        push_w.res[push_w.count] = simple_rec(sltok_pkg::KIND_ERROR,
                            sltok_pkg::TYPE_TEXT, '0, sltok_pkg::ERR_OVERFLOW);
                        push_w.count = push_w.count + 2'd1;
                    end else begin
                        push_w.res[push_w.count] = close_rec(ctype, tokens_reg, borg_reg,
                            bpos_reg, corg_reg, cpos_reg);
                        push_w.count = push_w.count + 2'd1;
                        done_count   = tokens_reg + sltok_pkg::TOK_W'(1);
                    end
                end
                if (!fail) begin
                    rec = simple_rec(sltok_pkg::KIND_LINE_DONE, sltok_pkg::TYPE_TEXT, '0,
                        sltok_pkg::ERR_NONE);
                    rec.token_number = done_count;
                    push_w.res[push_w.count] = rec;
                    push_w.count = push_w.count + 2'd1;
                end
            end
        end else if (mode_reg != MODE_ERROR) begin
            if (bpos_sum > (sltok_pkg::POS_W + 1)'(sltok_pkg::LINE_BYTES)) begin
                mode_next = MODE_ERROR;
                push_w.res[push_w.count] = simple_rec(sltok_pkg::KIND_ERROR,
                    sltok_pkg::TYPE_TEXT, '0, sltok_pkg::ERR_OVERFLOW);
                push_w.count = push_w.count + 2'd1;
            end else if (mode_reg == MODE_QUOTE && code_point_i == sltok_pkg::CH_QUOTE) begin
                // doubled quote inside a string: one literal quote
                bpos_next = bpos_sum[sltok_pkg::POS_W-1:0];
                cpos_next = cpos_reg + sltok_pkg::POS_W'(1);
                mode_next = MODE_STRING;
                push_w.res[push_w.count] = simple_rec(sltok_pkg::KIND_CHAR,
                    sltok_pkg::TYPE_TEXT, sltok_pkg::CH_QUOTE, sltok_pkg::ERR_NONE);
                push_w.count = push_w.count + 2'd1;
            end else begin
                // close the token the new character ends, at the old position
                pre_close = (mode_reg == MODE_QUOTE) ||
                            (mode_reg == MODE_SPACE && code_point_i != sltok_pkg::CH_SPACE) ||
                            (mode_reg == MODE_NORMAL && pend_reg &&
                             (code_point_i == sltok_pkg::CH_SPACE ||
                              code_point_i == sltok_pkg::CH_PIPE));
                if (pre_close) begin
                    if (tokens_reg >= limit_eff) begin
                        fail      = 1'b1;
                        mode_next = MODE_ERROR;
                        push_w.res[push_w.count] = simple_rec(sltok_pkg::KIND_ERROR,
                            sltok_pkg::TYPE_TEXT, '0, sltok_pkg::ERR_OVERFLOW);
                        push_w.count = push_w.count + 2'd1;
                    end else begin
                        push_w.res[push_w.count] = close_rec(ctype, tokens_reg, borg_reg,
                            bpos_reg, corg_reg, cpos_reg);
                        push_w.count = push_w.count + 2'd1;
                        tokens_next  = tokens_reg + sltok_pkg::TOK_W'(1);
                        borg_next    = bpos_reg;
                        corg_next    = cpos_reg;
                        pend_next    = 1'b0;
                        if (mode_reg == MODE_QUOTE || mode_reg == MODE_SPACE) begin
                            mode_next = MODE_NORMAL;
                        end
                    end
                end
                if (!fail) begin
                    bpos_next = bpos_sum[sltok_pkg::POS_W-1:0];
                    cpos_next = cpos_reg + sltok_pkg::POS_W'(1);
                    unique case (mode_next)
                        MODE_STRING: begin
                            if (code_point_i == sltok_pkg::CH_QUOTE) begin
                                mode_next = MODE_QUOTE;
                            end else begin
                                push_w.res[push_w.count] = simple_rec(sltok_pkg::KIND_CHAR,
                                    sltok_pkg::TYPE_TEXT, code_point_i, sltok_pkg::ERR_NONE);
                                push_w.count = push_w.count + 2'd1;
                            end
                        end
                        MODE_SPACE: begin
                            push_w.res[push_w.count] = simple_rec(sltok_pkg::KIND_CHAR,
                                sltok_pkg::TYPE_SPACE, code_point_i, sltok_pkg::ERR_NONE);
                            push_w.count = push_w.count + 2'd1;
                        end
                        default: begin
                            if (code_point_i == sltok_pkg::CH_SPACE) begin
                                mode_next = MODE_SPACE;
                                push_w.res[push_w.count] = simple_rec(sltok_pkg::KIND_CHAR,
                                    sltok_pkg::TYPE_SPACE, code_point_i, sltok_pkg::ERR_NONE);
                                push_w.count = push_w.count + 2'd1;
                            end else if (code_point_i == sltok_pkg::CH_PIPE) begin
                                push_w.res[push_w.count] = simple_rec(sltok_pkg::KIND_CHAR,
                                    sltok_pkg::TYPE_PIPE, code_point_i, sltok_pkg::ERR_NONE);
                                push_w.count = push_w.count + 2'd1;
                                // a pipe is a token of its own, closed right away
                                if (tokens_next >= limit_eff) begin
                                    mode_next = MODE_ERROR;
                                    push_w.res[push_w.count] = simple_rec(
                                        sltok_pkg::KIND_ERROR, sltok_pkg::TYPE_TEXT, '0,
                                        sltok_pkg::ERR_OVERFLOW);
                                    push_w.count = push_w.count + 2'd1;
                                end else begin
                                    push_w.res[push_w.count] = close_rec(
                                        sltok_pkg::TYPE_PIPE, tokens_next, borg_next,
                                        bpos_next, corg_next, cpos_next);
                                    push_w.count = push_w.count + 2'd1;
                                    tokens_next  = tokens_next + sltok_pkg::TOK_W'(1);
                                    borg_next    = bpos_next;
                                    corg_next    = cpos_next;
                                    pend_next    = 1'b0;
                                end
                            end else if (code_point_i == sltok_pkg::CH_QUOTE) begin
                                mode_next = MODE_STRING;
                            end else begin
                                pend_next = 1'b1;
                                push_w.res[push_w.count] = simple_rec(sltok_pkg::KIND_CHAR,
                                    sltok_pkg::TYPE_TEXT, code_point_i, sltok_pkg::ERR_NONE);
                                push_w.count = push_w.count + 2'd1;
                            end
                        end
                    endcase
                end
            end
        end

        if (push_w.count != '0) begin
            push_w.res[push_w.count - 2'd1].last = 1'b1;
        end
        if (!accept_i) begin
            push_w.count = '0;
        end
    end

    assign push_o = push_w;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_NORMAL;
            pend_reg   <= 1'b0;
            bpos_reg   <= '0;
            cpos_reg   <= '0;
            borg_reg   <= '0;
            corg_reg   <= '0;
            tokens_reg <= '0;
            limit_reg  <= sltok_pkg::TOK_W'(256);
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (accept_i) begin
                mode_reg   <= mode_next;
                pend_reg   <= pend_next;
                bpos_reg   <= bpos_next;
                cpos_reg   <= cpos_next;
                borg_reg   <= borg_next;
                corg_reg   <= corg_next;
                tokens_reg <= tokens_next;
            end
        end
    end

endmodule

// ===== rtl/sltok_queue.sv =====
// Result queue for the shell line tokenizer.
// Takes up to three result records per cycle and hands them out one per transaction.
// Depends on sltok_pkg.
module sltok_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  sltok_pkg::push_t    push_i,
    input  logic                pop_ready_i,
    output logic                head_valid_o,
    output sltok_pkg::result_t  head_o,
    output logic                room_o
);

    sltok_pkg::result_t               entry_reg [sltok_pkg::QUEUE_DEPTH];
    logic [sltok_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [sltok_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [sltok_pkg::QCNT_W-1:0]     count_reg;
    logic                             pop;

    assign head_valid_o = (count_reg != '0);
    assign head_o       = entry_reg[rd_ptr_reg];
    assign pop          = head_valid_o && pop_ready_i;
    // keep room for the worst-case burst of one transaction
    assign room_o       = (count_reg <=
                           sltok_pkg::QCNT_W'(sltok_pkg::QUEUE_DEPTH - sltok_pkg::MAX_RES));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + sltok_pkg::QPTR_W'(push_i.count);
            rd_ptr_reg <= rd_ptr_reg + sltok_pkg::QPTR_W'(pop);
            count_reg  <= count_reg + sltok_pkg::QCNT_W'(push_i.count)
                          - sltok_pkg::QCNT_W'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < sltok_pkg::MAX_RES; i++) begin
            if (sltok_pkg::RES_CNT_W'(i) < push_i.count) begin
                entry_reg[wr_ptr_reg + sltok_pkg::QPTR_W'(i)] <= push_i.res[i];
            end
        end
    end

endmodule
